// File: sv/mdsd_pkg.sv
// Shared types, constants and constellation tables of the symbol demapper.
`timescale 1ns / 1ps
package mdsd_pkg;

   // Search size and counter width.
   localparam int MAX_POINTS = 16;
   localparam int COUNT_BITS = 20;
   localparam int PT_W       = $clog2(MAX_POINTS);

   // Field widths of the items.
   localparam int SAMPLE_W   = 16;
   localparam int SYMBOL_W   = 4;
   localparam int NBITS_W    = 3;
   localparam int SYM_OUT_W  = 20;
   localparam int ERR_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MODULATION      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BITS_PER_SYMBOL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_LIMIT     = 2'd2;

   // Modulation codes.
   localparam logic [1:0] MOD_PAM = 2'd0;
   localparam logic [1:0] MOD_PSK = 2'd1;
   localparam logic [1:0] MOD_QAM = 2'd2;

   // Register reset values.
   localparam logic [1:0]       RST_MODULATION  = MOD_QAM;
   localparam logic [2:0]       RST_BITS_PER_SYM = 3'd4;
   localparam logic [ERR_W-1:0] RST_ERROR_LIMIT = 16'd100;

   typedef logic signed [SAMPLE_W-1:0] coord_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic issue;
      logic commit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_point;
      logic out_free;
   } dp_status_type;

   // In-phase coordinates, [family][k-1][point], Q3.12, unit RMS.
   localparam coord_type ROM_I [3][4][16] = '{
      '{ // PAM
         '{0: -16'sd4096, 1: 16'sd4096, default: 16'sd0},
         '{0: -16'sd5495, 1: -16'sd1832, 2: 16'sd1832, 3: 16'sd5495, default: 16'sd0},
         '{0: -16'sd6257, 1: -16'sd4469, 2: -16'sd2681, 3: -16'sd894,
           4: 16'sd894, 5: 16'sd2681, 6: 16'sd4469, 7: 16'sd6257, default: 16'sd0},
         '{-16'sd6664, -16'sd5776, -16'sd4887, -16'sd3998,
           -16'sd3110, -16'sd2221, -16'sd1333, -16'sd444,
           16'sd444, 16'sd1333, 16'sd2221, 16'sd3110,
           16'sd3998, 16'sd4887, 16'sd5776, 16'sd6664}
      },
      '{ // PSK
         '{0: -16'sd4096, 1: 16'sd4096, default: 16'sd0},
         '{0: 16'sd4096, 1: 16'sd0, 2: -16'sd4096, 3: 16'sd0, default: 16'sd0},
         '{0: 16'sd4096, 1: 16'sd2896, 2: 16'sd0, 3: -16'sd2896,
           4: -16'sd4096, 5: -16'sd2896, 6: 16'sd0, 7: 16'sd2896, default: 16'sd0},
         '{16'sd4096, 16'sd3784, 16'sd2896, 16'sd1567,
           16'sd0, -16'sd1567, -16'sd2896, -16'sd3784,
           -16'sd4096, -16'sd3784, -16'sd2896, -16'sd1567,
           16'sd0, 16'sd1567, 16'sd2896, 16'sd3784}
      },
      '{ // QAM
         '{0: -16'sd4096, 1: 16'sd4096, default: 16'sd0},
         '{0: 16'sd4096, 1: 16'sd0, 2: -16'sd4096, 3: 16'sd0, default: 16'sd0},
         '{0: 16'sd5017, 1: 16'sd1672, 2: -16'sd1672, 3: -16'sd5017,
           4: -16'sd5017, 5: -16'sd1672, 6: 16'sd1672, 7: 16'sd5017, default: 16'sd0},
         '{-16'sd3886, -16'sd1295, 16'sd1295, 16'sd3886,
           16'sd3886, 16'sd1295, -16'sd1295, -16'sd3886,
           -16'sd3886, -16'sd1295, 16'sd1295, 16'sd3886,
           16'sd3886, 16'sd1295, -16'sd1295, -16'sd3886}
      }
   };

   // Quadrature coordinates, same layout.
   localparam coord_type ROM_Q [3][4][16] = '{
      '{ // PAM
         '{default: 16'sd0},
         '{default: 16'sd0},
         '{default: 16'sd0},
         '{default: 16'sd0}
      },
      '{ // PSK
         '{default: 16'sd0},
         '{0: 16'sd0, 1: 16'sd4096, 2: 16'sd0, 3: -16'sd4096, default: 16'sd0},
         '{0: 16'sd0, 1: 16'sd2896, 2: 16'sd4096, 3: 16'sd2896,
           4: 16'sd0, 5: -16'sd2896, 6: -16'sd4096, 7: -16'sd2896, default: 16'sd0},
         '{16'sd0, 16'sd1567, 16'sd2896, 16'sd3784,
           16'sd4096, 16'sd3784, 16'sd2896, 16'sd1567,
           16'sd0, -16'sd1567, -16'sd2896, -16'sd3784,
           -16'sd4096, -16'sd3784, -16'sd2896, -16'sd1567}
      },
      '{ // QAM
         '{default: 16'sd0},
         '{0: 16'sd0, 1: 16'sd4096, 2: 16'sd0, 3: -16'sd4096, default: 16'sd0},
         '{0: 16'sd1672, 1: 16'sd1672, 2: 16'sd1672, 3: 16'sd1672,
           4: -16'sd1672, 5: -16'sd1672, 6: -16'sd1672, 7: -16'sd1672,
           default: 16'sd0},
         '{16'sd3886, 16'sd3886, 16'sd3886, 16'sd3886,
           16'sd1295, 16'sd1295, 16'sd1295, 16'sd1295,
           -16'sd1295, -16'sd1295, -16'sd1295, -16'sd1295,
           -16'sd3886, -16'sd3886, -16'sd3886, -16'sd3886}
      }
   };

endpackage

// File: sv/mdsd_if.sv
// Valid/ready channel interfaces for the demapper's request and response items.
`timescale 1ns / 1ps
interface mdsd_req_if;
   import mdsd_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] rx_inphase;
   logic signed [SAMPLE_W-1:0] rx_quadrature;
   logic [SYMBOL_W-1:0]        sent_symbol;
   logic                       clear_counts;

   modport source (output valid, rx_inphase, rx_quadrature, sent_symbol, clear_counts,
                   input ready);
   modport sink (input valid, rx_inphase, rx_quadrature, sent_symbol, clear_counts,
                 output ready);
endinterface

interface mdsd_rsp_if;
   import mdsd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [SYMBOL_W-1:0]  est_symbol;
   logic                 symbol_wrong;
   logic [NBITS_W-1:0]   bit_error_count;
   logic [SYM_OUT_W-1:0] symbol_total;
   logic [ERR_W-1:0]     error_total;
   logic                 limit_reached;

   modport source (output valid, est_symbol, symbol_wrong, bit_error_count, symbol_total,
                   error_total, limit_reached, input ready);
   modport sink (input valid, est_symbol, symbol_wrong, bit_error_count, symbol_total,
                 error_total, limit_reached, output ready);
endinterface

// File: sv/mdsd_ctrl.sv
// Sequencing state machine of the demapper: accept, point scan, drain and result commit.
`timescale 1ns / 1ps
module mdsd_ctrl
   import mdsd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.last_point) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/mdsd_datapath.sv
// Demapper datapath: settings, distance unit, running minimum, counters and result register.
`timescale 1ns / 1ps
module mdsd_datapath
   import mdsd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // Configuration writes.
   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data,
   // Request payload.
   input  logic signed [SAMPLE_W-1:0] req_rx_inphase,
   input  logic signed [SAMPLE_W-1:0] req_rx_quadrature,
   input  logic [SYMBOL_W-1:0]        req_sent_symbol,
   input  logic                       req_clear_counts,
   // Controller link.
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   // Response register.
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [SYMBOL_W-1:0]        rsp_est_symbol,
   output logic                       rsp_symbol_wrong,
   output logic [NBITS_W-1:0]         rsp_bit_error_count,
   output logic [SYM_OUT_W-1:0]       rsp_symbol_total,
   output logic [ERR_W-1:0]           rsp_error_total,
   output logic                       rsp_limit_reached
);

   localparam logic [COUNT_BITS-1:0] SYM_MAX = '1;
   localparam logic [ERR_W-1:0]      ERR_MAX = '1;

   // Settings registers.
   logic [1:0]       modulation_ff;
   logic [2:0]       bits_per_symbol_ff;
   logic [ERR_W-1:0] error_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulation_ff      <= RST_MODULATION;
         bits_per_symbol_ff <= RST_BITS_PER_SYM;
         error_limit_ff     <= RST_ERROR_LIMIT;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MODULATION:      modulation_ff      <= csr_write_data[1:0];
            CSR_BITS_PER_SYMBOL: bits_per_symbol_ff <= csr_write_data[2:0];
            CSR_ERROR_LIMIT:     error_limit_ff     <= csr_write_data[ERR_W-1:0];
            default:             ;
         endcase
      end
   end

   // Effective family, k and point count.
   logic [1:0] fam;
   logic [2:0] k_eff;
   logic [1:0] k_idx;
   logic [4:0] npts_full;
   logic [4:0] npts;
   logic [4:0] mask_full;
   logic [3:0] mask;

   always_comb begin
      fam = (modulation_ff > MOD_QAM) ? MOD_QAM : modulation_ff;
      if (bits_per_symbol_ff == 3'd0) begin
         k_eff = 3'd1;
      end else if (bits_per_symbol_ff > 3'd4) begin
         k_eff = 3'd4;
      end else begin
         k_eff = bits_per_symbol_ff;
      end
      k_idx     = 2'(k_eff - 3'd1);
      npts_full = 5'd1 << k_eff;
      npts      = (npts_full > 5'(MAX_POINTS)) ? 5'(MAX_POINTS) : npts_full;
      mask_full = npts_full - 5'd1;
      mask      = mask_full[3:0];
   end

   // Latched item.
   logic signed [SAMPLE_W-1:0] rx_i_ff;
   logic signed [SAMPLE_W-1:0] rx_q_ff;
   logic [SYMBOL_W-1:0]        sent_ff;
   logic                       clear_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rx_i_ff  <= req_rx_inphase;
         rx_q_ff  <= req_rx_quadrature;
         sent_ff  <= req_sent_symbol;
         clear_ff <= req_clear_counts;
      end
   end

   // Point counter, one constellation point per cycle.
   logic [PT_W-1:0] pt_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pt_ff <= '0;
      end else if (cmd.issue) begin
         pt_ff <= pt_ff + PT_W'(1);
      end
   end

   assign status.last_point = (5'(pt_ff) == (npts - 5'd1));

   // Distance stage: table lookup, differences and squares.
   coord_type          pt_i;
   coord_type          pt_q;
   logic signed [16:0] diff_i;
   logic signed [16:0] diff_q;
   logic signed [33:0] prod_i;
   logic signed [33:0] prod_q;

   always_comb begin
      pt_i   = ROM_I[fam][k_idx][4'(pt_ff)];
      pt_q   = ROM_Q[fam][k_idx][4'(pt_ff)];
      diff_i = 17'(rx_i_ff) - 17'(pt_i);
      diff_q = 17'(rx_q_ff) - 17'(pt_q);
      prod_i = diff_i * diff_i;
      prod_q = diff_q * diff_q;
   end

   logic [30:0]     sq_i_ff;
   logic [30:0]     sq_q_ff;
   logic [PT_W-1:0] sq_idx_ff;
   logic            sq_first_ff;
   logic            sq_valid_ff;

   always_ff @(posedge clock) begin
      sq_i_ff     <= prod_i[30:0];
      sq_q_ff     <= prod_q[30:0];
      sq_idx_ff   <= pt_ff;
      sq_first_ff <= (pt_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= cmd.issue;
      end
   end

   // Running minimum; a strict compare keeps the lowest index on a tie.
   logic [31:0]     cur_dist;
   logic [31:0]     best_ff;
   logic [PT_W-1:0] best_idx_ff;

   assign cur_dist = {1'b0, sq_i_ff} + {1'b0, sq_q_ff};

   always_ff @(posedge clock) begin
      if (sq_valid_ff && (sq_first_ff || (cur_dist < best_ff))) begin
         best_ff     <= cur_dist;
         best_idx_ff <= sq_idx_ff;
      end
   end

   // Result fields and counter update for the item being committed.
   logic [3:0]            est;
   logic [3:0]            diff_bits;
   logic [NBITS_W-1:0]    nbits;
   logic [COUNT_BITS-1:0] base_sym;
   logic [ERR_W-1:0]      base_err;
   logic                  base_stop;
   logic [COUNT_BITS-1:0] sym_in;
   logic [ERR_W-1:0]      err_in;
   logic                  stop_in;

   logic [COUNT_BITS-1:0] sym_cnt_ff;
   logic [ERR_W-1:0]      err_cnt_ff;
   logic                  stop_ff;

   always_comb begin
      est       = 4'(best_idx_ff);
      diff_bits = (est ^ sent_ff) & mask;
      nbits     = '0;
      for (int b = 0; b < 4; b++) begin
         nbits = nbits + NBITS_W'(diff_bits[b]);
      end
      base_sym  = clear_ff ? '0 : sym_cnt_ff;
      base_err  = clear_ff ? '0 : err_cnt_ff;
      base_stop = clear_ff ? 1'b0 : stop_ff;
      sym_in    = base_sym;
      err_in    = base_err;
      stop_in   = base_stop;
      if (!base_stop) begin
         if (base_sym != SYM_MAX) begin
            sym_in = base_sym + COUNT_BITS'(1);
         end
         if ((diff_bits != 4'd0) && (base_err != ERR_MAX)) begin
            err_in = base_err + ERR_W'(1);
         end
         stop_in = (err_in >= error_limit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_cnt_ff <= '0;
         err_cnt_ff <= '0;
         stop_ff    <= 1'b0;
      end else if (cmd.commit) begin
         sym_cnt_ff <= sym_in;
         err_cnt_ff <= err_in;
         stop_ff    <= stop_in;
      end
   end

   // Output register; a waiting result does not hold up the next item's scan.
   logic                 rsp_valid_ff;
   logic [SYMBOL_W-1:0]  rsp_est_ff;
   logic                 rsp_wrong_ff;
   logic [NBITS_W-1:0]   rsp_nbits_ff;
   logic [SYM_OUT_W-1:0] rsp_sym_ff;
   logic [ERR_W-1:0]     rsp_err_ff;
   logic                 rsp_stop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_est_ff   <= est;
         rsp_wrong_ff <= (diff_bits != 4'd0);
         rsp_nbits_ff <= nbits;
         rsp_sym_ff   <= SYM_OUT_W'(sym_in);
         rsp_err_ff   <= err_in;
         rsp_stop_ff  <= stop_in;
      end
   end

   assign status.out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_est_symbol      = rsp_est_ff;
   assign rsp_symbol_wrong    = rsp_wrong_ff;
   assign rsp_bit_error_count = rsp_nbits_ff;
   assign rsp_symbol_total    = rsp_sym_ff;
   assign rsp_error_total     = rsp_err_ff;
   assign rsp_limit_reached   = rsp_stop_ff;

   // A result is never written over one that has not been taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result committed while output register is occupied");

   // The totals move only when an item is committed.
   assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> ($stable(sym_cnt_ff) && $stable(err_cnt_ff)))
      else $error("totals changed without a committed item");

   // The stop flag drops only through a clearing item.
   assert property (@(posedge clock) disable iff (reset)
      (stop_ff && !(cmd.commit && clear_ff)) |=> stop_ff)
      else $error("stop flag dropped without a clear");

   // A commit always presents a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");

endmodule

// File: sv/min_distance_symbol_demapper_unit.sv
// Top level of the minimum-distance symbol demapper with error counting.
`timescale 1ns / 1ps
// Usage:
// The req channel carries one received I/Q sample (signed Q3.12), the sent
// symbol index and a clear flag; the rsp channel returns the nearest point's
// index, the symbol-error flag, the bit-error count and the running totals.
// Both channels move an item when valid and ready are high at a clock edge.
// Settings are written through the csr port (index 0 modulation, 1 bits per
// symbol, 2 error limit) while no item is in flight.
// One constellation point is compared per cycle by a single distance unit;
// after the scan of all N points, where N is the number of points (2 to 16),
// a drain state and then a commit state write the result to the output register.
// The next item is accepted in the cycle after a result is written, so an item
// is not taken while the one before it is still being scanned or committed.
// A finished result sits in an output register; the next item is accepted and
// scanned while it waits, and a second result waits in the datapath until the
// receiver takes the first one.
// Synchronous reset restores QAM, 4 bits per symbol, an error limit of 100 and
// clears the totals, the stop flag and any item in flight.
module min_distance_symbol_demapper_unit
   import mdsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   mdsd_req_if.sink              req,
   mdsd_rsp_if.source            rsp
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer.
   mdsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath with the response register.
   mdsd_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_rx_inphase      (req.rx_inphase),
      .req_rx_quadrature   (req.rx_quadrature),
      .req_sent_symbol     (req.sent_symbol),
      .req_clear_counts    (req.clear_counts),
      .cmd                 (cmd),
      .status              (status),
      .rsp_ready           (rsp.ready),
      .rsp_valid           (rsp.valid),
      .rsp_est_symbol      (rsp.est_symbol),
      .rsp_symbol_wrong    (rsp.symbol_wrong),
      .rsp_bit_error_count (rsp.bit_error_count),
      .rsp_symbol_total    (rsp.symbol_total),
      .rsp_error_total     (rsp.error_total),
      .rsp_limit_reached   (rsp.limit_reached)
   );

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the minimum-distance symbol demapper unit.
`timescale 1ns / 1ps
module testbench;
   import mdsd_pkg::*;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 30;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int PHASE_ITEMS   = 30;
   localparam int RANDOM_PHASES = 20;
   localparam int MAX_REPORTS   = 40;

   // The package names three families; code 3 is decoded like QAM.
   localparam logic [1:0] MOD_UNUSED = 2'd3;

   // Positive PAM levels for 2, 4, 8 and 16 points; the level set of a
   // constellation with M points starts at entry M/2 - 1.
   localparam int PAM_LEVEL [15] = '{4096, 1832, 5495, 894, 2681, 4469, 6257,
                                     444, 1333, 2221, 3110, 3998, 4887, 5776, 6664};
   // Cosine of n * 22.5 degrees at unit amplitude; PSK points sit on this grid.
   localparam int UNIT_COS [16] = '{4096, 3784, 2896, 1567, 0, -1567, -2896, -3784,
                                    -4096, -3784, -2896, -1567, 0, 1567, 2896, 3784};
   localparam int QAM8_I [8]      = '{5017, 1672, -1672, -5017, -5017, -1672, 1672, 5017};
   localparam int QAM16_LEVEL [4] = '{-3886, -1295, 1295, 3886};

   // Values used for edge-of-range samples and noise spread.
   localparam int EXTREMES [4]  = '{-32768, 32767, 0, -1};
   localparam int NOISE_AMP [4] = '{0, 300, 1500, 6000};

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] rx_i;
      logic signed [SAMPLE_W-1:0] rx_q;
      logic [SYMBOL_W-1:0]        sent;
      logic                       clear;
   } rx_item_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0]  est;
      logic                 wrong;
      logic [NBITS_W-1:0]   bit_errors;
      logic [SYM_OUT_W-1:0] symbols;
      logic [ERR_W-1:0]     errors;
      logic                 limit;
   } demap_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   mdsd_req_if req_ch ();
   mdsd_rsp_if rsp_ch ();

   min_distance_symbol_demapper_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req              (req_ch),
      .rsp              (rsp_ch)
   );

   // Predicted register contents and counting state.
   logic [1:0]            cfg_modulation;
   logic [2:0]            cfg_bits;
   logic [ERR_W-1:0]      cfg_limit;
   logic [COUNT_BITS-1:0] symbol_count;
   logic [ERR_W-1:0]      error_count;
   logic                  counting_frozen;

   demap_result_type pending_results [$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   bit               steady_flow = 1'b0;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Run length guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Length of an idle stretch: mostly none, sometimes short, rarely long.
   function automatic int idle_length();
      int r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Bits per symbol after out-of-range values are folded into 1..4.
   function automatic int effective_bits();
      if (cfg_bits == 3'd0) return 1;
      if (cfg_bits > 3'd4) return 4;
      return int'(cfg_bits);
   endfunction

   function automatic logic [1:0] effective_family();
      return (cfg_modulation == MOD_UNUSED) ? MOD_QAM : cfg_modulation;
   endfunction

   // Coordinates of point p of the constellation with 2^k points.
   function automatic void point_coord(input logic [1:0] fam, input int k, input int p,
                                       output int ci, output int cq);
      int npts;
      int half;
      npts = 1 << k;
      half = npts / 2;
      cq = 0;
      if (k == 1) begin
         // Every two-point set is antipodal on the in-phase axis.
         ci = (p == 0) ? -4096 : 4096;
      end else if (fam == MOD_PAM) begin
         ci = (p < half) ? -PAM_LEVEL[half - 1 + (half - 1 - p)] : PAM_LEVEL[half - 1 + p - half];
      end else if (fam == MOD_PSK || k == 2) begin
         // Four-point QAM coincides with four-point PSK.
         ci = UNIT_COS[(p * (16 / npts)) % 16];
         cq = UNIT_COS[(p * (16 / npts) + 12) % 16];
      end else if (k == 3) begin
         ci = QAM8_I[p];
         cq = (p < 4) ? 1672 : -1672;
      end else begin
         // Rows run top to bottom, alternating direction.
         ci = ((p / 4) % 2 == 0) ? QAM16_LEVEL[p % 4] : QAM16_LEVEL[3 - p % 4];
         cq = QAM16_LEVEL[3 - p / 4];
      end
   endfunction

   // Nearest-point decision and counter update for one accepted item.
   function automatic demap_result_type predict_demap(input rx_item_type item);
      int               k;
      int               npts;
      int               ci;
      int               cq;
      int               est;
      longint           di;
      longint           dq;
      longint           sq_dist;
      longint           best;
      logic [1:0]       fam;
      logic [3:0]       mask;
      logic [3:0]       diff;
      demap_result_type res;
      k = effective_bits();
      fam = effective_family();
      npts = 1 << k;
      if (npts > MAX_POINTS) npts = MAX_POINTS;
      mask = 4'((1 << k) - 1);
      if (item.clear) begin
         symbol_count = '0;
         error_count = '0;
         counting_frozen = 1'b0;
      end
      // Exact squared distance; strict compare keeps the lowest index on a tie.
      best = 0;
      est = 0;
      for (int p = 0; p < npts; p++) begin
         point_coord(fam, k, p, ci, cq);
         di = longint'($signed(item.rx_i)) - ci;
         dq = longint'($signed(item.rx_q)) - cq;
         sq_dist = di * di + dq * dq;
         if (p == 0 || sq_dist < best) begin
            best = sq_dist;
            est = p;
         end
      end
      diff = (4'(est) ^ item.sent) & mask;
      // Totals saturate and stop moving once the limit has been reached.
      if (!counting_frozen) begin
         if (symbol_count != '1) symbol_count = symbol_count + 1'b1;
         if (diff != 4'd0 && error_count != '1) error_count = error_count + 1'b1;
         if (error_count >= cfg_limit) counting_frozen = 1'b1;
      end
      res.est = 4'(est);
      res.wrong = (diff != 4'd0);
      res.bit_errors = NBITS_W'($countones(diff));
      res.symbols = symbol_count[SYM_OUT_W-1:0];
      res.errors = error_count;
      res.limit = counting_frozen;
      return res;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] clip_sample(input int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return SAMPLE_W'(v);
   endfunction

   function automatic rx_item_type make_item(input int ri, input int rq, input int sent,
                                             input bit clr);
      rx_item_type item;
      item.rx_i = clip_sample(ri);
      item.rx_q = clip_sample(rq);
      item.sent = SYMBOL_W'(sent);
      item.clear = clr;
      return item;
   endfunction

   // Mostly noisy copies of a constellation point, with some full-range
   // and edge-of-range samples mixed in.
   function automatic rx_item_type random_item();
      int k;
      int p;
      int ci;
      int cq;
      int amp;
      int r;
      int sent;
      k = effective_bits();
      p = $urandom_range(0, (1 << k) - 1);
      point_coord(effective_family(), k, p, ci, cq);
      r = $urandom_range(0, 99);
      if (r < 70) begin
         amp = NOISE_AMP[$urandom_range(0, 3)];
         ci = ci + $urandom_range(0, 2 * amp) - amp;
         cq = cq + $urandom_range(0, 2 * amp) - amp;
         // Upper bits beyond k are random; they must be ignored.
         sent = (r < 60) ? ((p | ($urandom_range(0, 15) << k)) & 15) : $urandom_range(0, 15);
      end else if (r < 90) begin
         ci = $urandom_range(0, 65535) - 32768;
         cq = $urandom_range(0, 65535) - 32768;
         sent = $urandom_range(0, 15);
      end else begin
         ci = EXTREMES[$urandom_range(0, 3)];
         cq = EXTREMES[$urandom_range(0, 3)];
         sent = $urandom_range(0, 15);
      end
      return make_item(ci, cq, sent, $urandom_range(0, 29) == 0);
   endfunction

   // Offer one item, wait for it to be taken and record its expected result.
   task automatic send_item(input rx_item_type item);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_inphase <= item.rx_i;
      req_ch.rx_quadrature <= item.rx_q;
      req_ch.sent_symbol <= item.sent;
      req_ch.clear_counts <= item.clear;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_results.push_back(predict_demap(item));
      @(negedge clock);
   endtask

   // Stop sending and let every outstanding result come back.
   task automatic wait_for_idle();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_MODULATION:      cfg_modulation = data[1:0];
         CSR_BITS_PER_SYMBOL: cfg_bits = data[2:0];
         CSR_ERROR_LIMIT:     cfg_limit = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Narrow registers get random upper data bits, which must be dropped.
   task automatic configure(input logic [1:0] modulation, input logic [2:0] bits,
                            input logic [ERR_W-1:0] limit);
      wait_for_idle();
      write_register(CSR_MODULATION, {14'($urandom), modulation});
      write_register(CSR_BITS_PER_SYMBOL, {13'($urandom), bits});
      write_register(CSR_ERROR_LIMIT, limit);
   endtask

   // Reset settings (16-QAM, limit 100): extreme samples, the four-way tie at
   // the origin and an exact point.
   task automatic test_reset_settings();
      send_item(make_item(0, 0, 5, 1'b0));
      send_item(make_item(32767, 32767, 3, 1'b0));
      send_item(make_item(-32768, -32768, 0, 1'b0));
      send_item(make_item(32767, -32768, 15, 1'b0));
      send_item(make_item(-32768, 32767, 0, 1'b1));
      send_item(make_item(1295, -1295, 10, 1'b0));
   endtask

   // Two- and four-point sets, with sent indexes wider than k.
   task automatic test_small_constellations();
      configure(MOD_PSK, 3'd1, 16'd100);
      send_item(make_item(0, 0, 15, 1'b0));
      send_item(make_item(4096, 0, 1, 1'b0));
      configure(MOD_QAM, 3'd1, 16'd100);
      send_item(make_item(-100, 5000, 14, 1'b0));
      configure(MOD_QAM, 3'd2, 16'd100);
      send_item(make_item(0, 4096, 1, 1'b0));
      send_item(make_item(3000, 3000, 13, 1'b0));
      configure(MOD_PSK, 3'd2, 16'd100);
      send_item(make_item(-4096, 0, 2, 1'b0));
   endtask

   // A tie between the two innermost 16-PAM levels resolves to the lower index; 8-PAM gets an extreme sample.
   task automatic test_pam_ties();
      configure(MOD_PAM, 3'd4, 16'd100);
      send_item(make_item(0, -32768, 7, 1'b0));
      configure(MOD_PAM, 3'd3, 16'd100);
      send_item(make_item(32767, 32767, 7, 1'b0));
   endtask

   // Unused modulation code and bits-per-symbol values outside 1..4.
   task automatic test_odd_settings();
      configure(MOD_UNUSED, 3'd3, 16'd100);
      send_item(make_item(5017, 1672, 0, 1'b0));
      configure(MOD_PSK, 3'd0, 16'd100);
      send_item(make_item(100, 0, 1, 1'b0));
      configure(MOD_PAM, 3'd7, 16'd100);
      send_item(make_item(-444, 0, 6, 1'b0));
   endtask

   // Zero limit freezes after the first counted item; a limit of one freezes
   // on the first error; a clear item releases the counters.
   task automatic test_error_limit();
      configure(MOD_QAM, 3'd4, 16'd0);
      send_item(make_item(-3886, 3886, 0, 1'b1));
      send_item(make_item(3886, 3886, 0, 1'b0));
      configure(MOD_QAM, 3'd4, 16'd1);
      send_item(make_item(3886, 3886, 0, 1'b1));
      send_item(make_item(3886, -3886, 1, 1'b0));
      send_item(make_item(-3886, 3886, 0, 1'b1));
   endtask

   // Phases of random items under changing settings, some with no idling.
   task automatic test_random_traffic();
      logic [1:0]       modulation;
      logic [2:0]       bits;
      logic [ERR_W-1:0] limit;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         modulation = 2'(ph % 4);
         bits = (ph < 8) ? 3'(ph) : 3'($urandom_range(1, 4));
         case (ph % 6)
            0:       limit = 16'd0;
            1:       limit = 16'd1;
            2:       limit = 16'hFFFF;
            3:       limit = 16'($urandom_range(2, 12));
            4:       limit = 16'd100;
            default: limit = 16'($urandom);
         endcase
         steady_flow = (ph % 5 == 4);
         configure(modulation, bits, limit);
         repeat (PHASE_ITEMS) send_item(random_item());
      end
      steady_flow = 1'b0;
   endtask

   // Receiver: ready toggles in random stretches.
   initial begin
      int hold;
      int stall;
      hold = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else begin
            stall = idle_length();
            if (stall == 0) begin
               rsp_ch.ready <= 1'b1;
               hold = $urandom_range(0, 6);
            end else begin
               rsp_ch.ready <= 1'b0;
               hold = stall - 1;
            end
         end
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      demap_result_type seen;
      demap_result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         seen.est = rsp_ch.est_symbol;
         seen.wrong = rsp_ch.symbol_wrong;
         seen.bit_errors = rsp_ch.bit_error_count;
         seen.symbols = rsp_ch.symbol_total;
         seen.errors = rsp_ch.error_total;
         seen.limit = rsp_ch.limit_reached;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected result: expected none, got est=%0d wrong=%0d",
                        $time, seen.est, seen.wrong,
                        " bits=%0d symbols=%0d errors=%0d limit=%0d",
                        seen.bit_errors, seen.symbols, seen.errors, seen.limit);
         end else begin
            want = pending_results.pop_front();
            if (seen.est !== want.est || seen.wrong !== want.wrong ||
                seen.bit_errors !== want.bit_errors || seen.symbols !== want.symbols ||
                seen.errors !== want.errors || seen.limit !== want.limit) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: mismatch: expected est=%0d wrong=%0d bits=%0d",
                           $time, want.est, want.wrong, want.bit_errors,
                           " symbols=%0d errors=%0d limit=%0d",
                           want.symbols, want.errors, want.limit);
                  $display("%0t:           got est=%0d wrong=%0d bits=%0d",
                           $time, seen.est, seen.wrong, seen.bit_errors,
                           " symbols=%0d errors=%0d limit=%0d",
                           seen.symbols, seen.errors, seen.limit);
               end
            end
         end
      end
   end

   // Reset, then the tests in turn.
   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.rx_inphase = '0;
      req_ch.rx_quadrature = '0;
      req_ch.sent_symbol = '0;
      req_ch.clear_counts = 1'b0;
      cfg_modulation = RST_MODULATION;
      cfg_bits = RST_BITS_PER_SYM;
      cfg_limit = RST_ERROR_LIMIT;
      symbol_count = '0;
      error_count = '0;
      counting_frozen = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_settings();
      test_small_constellations();
      test_pam_ties();
      test_odd_settings();
      test_error_limit();
      test_random_traffic();
      wait_for_idle();

      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
